/* hw/rtl/wgm_pkg.sv */
// Package for the wildcard glob matcher: sizes, character codes and shared types.
`timescale 1ns / 1ps

package wgm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int CHAR_W      = 8;

	localparam logic [CHAR_W-1:0] STAR_CODE  = 8'd42;
	localparam logic [CHAR_W-1:0] QMARK_CODE = 8'd63;

	localparam logic REQ_PATTERN  = 1'b0;
	localparam logic REQ_FILENAME = 1'b1;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic fire;
		logic pat_item;
		logic is_last;
		logic has_char;
	} ctl_t;

	// signals handed from one cell to the next
	typedef struct packed {
		logic fwd;   // literal or '?' match moves activity one position right
		logic clo;   // '*' closure: active star position also activates the next
		logic init;  // closure of the start vector over leading stars
	} link_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_t;

endpackage

/* hw/rtl/wgm_req_if.sv */
// Request channel interface: valid/ready with one pattern or filename character.
`timescale 1ns / 1ps

interface wgm_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_code;
	logic       has_char;
	logic       is_last;

	modport source (output valid, req_type, char_code, has_char, is_last, input ready);
	modport sink   (input valid, req_type, char_code, has_char, is_last, output ready);
endinterface

/* hw/rtl/wgm_rsp_if.sv */
// Result channel interface: valid/ready with the match outcome.
`timescale 1ns / 1ps

interface wgm_rsp_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, matched, pattern_overflow, input ready);
	modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

/* hw/rtl/wgm_cell.sv */
// One pattern position: stored character, its active bit and the links to its neighbor.
`timescale 1ns / 1ps

module wgm_cell import wgm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic              act_rst,
	input  logic              en,
	input  logic              wr,
	input  logic [CHAR_W-1:0] char_code,
	input  link_t             lin,
	output link_t             lout,
	output logic              act_adv
);

	logic [CHAR_W-1:0] char_q;
	logic              star_q;
	logic              qm_q;
	logic              act_q;

	logic star_eff;
	logic stay;
	logic hit;
	logic closed;
	logic act_d;

	// a character written this cycle already counts for the start vector
	assign star_eff  = wr ? (char_code == STAR_CODE) : star_q;
	assign lout.init = en & star_eff & lin.init;

	assign hit      = qm_q | (char_q == char_code);
	assign stay     = en & act_q & star_q;
	assign closed   = stay | lin.fwd | lin.clo;
	assign lout.fwd = en & act_q & ~star_q & hit;
	assign lout.clo = en & star_q & closed;

	assign act_adv = ctl.has_char ? closed : act_q;

	always_comb begin
		priority if (ctl.pat_item || ctl.is_last) begin
			act_d = lin.init;
		end else begin
			act_d = act_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			char_q <= char_code;
			star_q <= (char_code == STAR_CODE);
			qm_q   <= (char_code == QMARK_CODE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= act_rst;
		end else if (ctl.fire) begin
			act_q <= act_d;
		end
	end

endmodule

/* hw/rtl/wgm_out_fifo.sv */
// Two-entry result buffer between the matcher and the result channel.
`timescale 1ns / 1ps

module wgm_out_fifo import wgm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rsp_t             push_data,
	output logic             full,
	wgm_rsp_if.source        rsp
);

	rsp_t       data0_q;
	rsp_t       data1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop                  = rsp.valid & rsp.ready;
	assign full                 = (cnt_q == 2'd2);
	assign rsp.valid            = (cnt_q != 2'd0);
	assign rsp.matched          = data0_q.matched;
	assign rsp.pattern_overflow = data0_q.pattern_overflow;

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					data0_q <= push_data;
				end else begin
					data1_q <= push_data;
				end
			end
			2'b01: begin
				data0_q <= data1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					data0_q <= push_data;
				end else begin
					data0_q <= data1_q;
					data1_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/wildcard_glob_match.sv */
// Wildcard glob matcher: a row of pattern cells updated once per filename character.
// Throughput: one request per cycle while ready is high; the cell row updates all positions together.
// Result: written into the registered output buffer when the last filename request is accepted.
// ready drops only while two results wait in the output buffer.
// Reset: empty pattern, only position zero active; the store is not cleared and
// no clearing pass runs, so the block takes requests right after reset.
`timescale 1ns / 1ps

module wildcard_glob_match import wgm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	wgm_req_if.sink   req,
	wgm_rsp_if.source rsp
);

	logic             fire;
	logic             pat;
	logic             full;
	ctl_t             ctl;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_base;
	logic [LEN_W-1:0] len_d;
	logic             loading_q;
	logic             ovf_q;
	logic             act_end_q;
	logic             store_ok;

	logic [MAX_PATTERN-1:0] en;
	logic [MAX_PATTERN-1:0] wr;
	logic [MAX_PATTERN:0]   adv;
	link_t                  lnk [MAX_PATTERN+1];

	rsp_t push_data;
	logic push;

	assign req.ready = ~full;
	assign fire      = req.valid & req.ready;
	assign pat       = fire & (req.req_type == REQ_PATTERN);

	assign ctl.fire     = fire;
	assign ctl.pat_item = (req.req_type == REQ_PATTERN);
	assign ctl.is_last  = req.is_last;
	assign ctl.has_char = req.has_char;

	// a pattern request outside a load starts a new pattern
	assign len_base = loading_q ? len_q : '0;
	assign store_ok = (len_base < LEN_W'(MAX_PATTERN));

	always_comb begin
		priority if (pat && req.has_char && store_ok) begin
			len_d = len_base + LEN_W'(1);
		end else if (pat) begin
			len_d = len_base;
		end else begin
			len_d = len_q;
		end
	end

	assign lnk[0] = '{fwd: 1'b0, clo: 1'b0, init: 1'b1};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign en[i] = (LEN_W'(i) < len_d);
		assign wr[i] = pat & req.has_char & (len_base == LEN_W'(i));

		wgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.act_rst   (1'(i == 0)),
			.en        (en[i]),
			.wr        (wr[i]),
			.char_code (req.char_code),
			.lin       (lnk[i]),
			.lout      (lnk[i+1]),
			.act_adv   (adv[i])
		);
	end

	// position past the last cell
	assign adv[MAX_PATTERN] = req.has_char ? (lnk[MAX_PATTERN].fwd | lnk[MAX_PATTERN].clo)
	                                       : act_end_q;

	assign push                       = fire & (req.req_type == REQ_FILENAME) & req.is_last;
	assign push_data.matched          = adv[len_q];
	assign push_data.pattern_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			loading_q <= 1'b0;
			ovf_q     <= 1'b0;
			act_end_q <= 1'b0;
		end else if (fire) begin
			len_q <= len_d;
			if (pat) begin
				loading_q <= ~req.is_last;
				ovf_q     <= (loading_q & ovf_q) | (req.has_char & ~store_ok);
				act_end_q <= lnk[MAX_PATTERN].init;
			end else begin
				loading_q <= 1'b0;
				act_end_q <= req.is_last ? lnk[MAX_PATTERN].init : adv[MAX_PATTERN];
			end
		end
	end

	wgm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.rsp       (rsp)
	);

endmodule
